// ----- rtl/sitcrd_pkg.sv -----
// ----------------------------------------------------------------------------
// sitcrd_pkg
// Shared constants and controller/datapath interface types for the
// signed integer to custom radix digit converter.
// ----------------------------------------------------------------------------
package sitcrd_pkg;

  localparam int SYMBOL_SLOTS_DEF = 128;
  localparam int VALUE_BITS_DEF   = 32;

  localparam int RADIX_W       = 8;
  localparam int SLOT_W        = 7;
  localparam int CHAR_W        = 8;
  localparam int DIGIT_W       = 7;
  localparam int IN_FIXED_BITS = SLOT_W + CHAR_W;
  localparam int CNT_W         = 8;
  localparam int SEEN_DEPTH    = 128;
  localparam int SEEN_AW       = 7;
  localparam int MIN_RADIX     = 2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd10;

  // printable range limits and forbidden symbols
  localparam logic [CHAR_W-1:0] SYM_LOW  = 8'd32;
  localparam logic [CHAR_W-1:0] SYM_HIGH = 8'd127;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

  // request kinds on s_tuser
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  typedef struct packed {
    logic load;          // write symbol table from input
    logic capture;       // latch value, reset counters
    logic clr_wr;        // clear one seen entry
    logic seen_mark;     // mark current symbol seen, advance index
    logic tab_rd_digit;  // table read address from digit stack
    logic div_step;      // one restoring division step
    logic push;          // push remainder digit
    logic emit_sign;     // load '-' into output register
    logic emit_digit;    // load digit symbol into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic len_bad;
    logic sym_bad;
    logic seen_hit;
    logic k_last;
    logic clr_last;
    logic neg;
    logic div_last;
    logic quot_zero;
    logic depth_one;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/signed_int_to_custom_radix_digits_top.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_custom_radix_digits_top
// Signed integer to text in the radix set over cfg, with digits from a loaded symbol table.
//
//  channel  dir  handshake               payload
//  s        in   s_tvalid / s_tready     s_tuser: req_type; s_tdata: slot, symbol, value
//  m        out  m_tvalid / m_tready     m_tdata: out_char; m_tlast: last
//  cfg      in   cfg_valid / cfg_ready   cfg_data: radix_length
//
// A load writes one slot of the symbol table. A conversion clears the
// SEEN_DEPTH (128) entries of the seen map, checks each symbol of the base,
// runs the restoring divider once per digit and then emits the characters
// most significant first.
// Reset sets radix_length to 10; the symbol table holds nothing until loaded.
// A stalled m channel holds the sequencer at its next character.
// ----------------------------------------------------------------------------
module signed_int_to_custom_radix_digits_top #(
  parameter int SYMBOL_SLOTS = sitcrd_pkg::SYMBOL_SLOTS_DEF,
  parameter int VALUE_BITS   = sitcrd_pkg::VALUE_BITS_DEF,
  localparam int S_DATA_W = ((sitcrd_pkg::IN_FIXED_BITS + VALUE_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [S_DATA_W-1:0]            s_tdata,   // slot, symbol, value, zero pad
  input  logic                           s_tuser,   // req_type
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sitcrd_pkg::CHAR_W-1:0]  m_tdata,   // out_char
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sitcrd_pkg::RADIX_W-1:0] cfg_data
);

  sitcrd_pkg::ctrl_cmd_t cmd;
  sitcrd_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  sitcrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sitcrd_dp #(
    .SYMBOL_SLOTS (SYMBOL_SLOTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- rtl/sitcrd_ram.sv -----
// ----------------------------------------------------------------------------
// sitcrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sitcrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sitcrd_dp.sv -----
// ----------------------------------------------------------------------------
// sitcrd_dp
// Datapath: radix register, symbol table, seen map, digit stack,
// restoring divider and output register.
// ----------------------------------------------------------------------------
module sitcrd_dp #(
  parameter int SYMBOL_SLOTS = sitcrd_pkg::SYMBOL_SLOTS_DEF,
  parameter int VALUE_BITS   = sitcrd_pkg::VALUE_BITS_DEF,
  localparam int S_DATA_W = ((sitcrd_pkg::IN_FIXED_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int TAB_AW   = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1,
  localparam int STK_AW   = $clog2(VALUE_BITS),
  localparam int DEP_W    = $clog2(VALUE_BITS + 1),
  localparam int BC_W     = $clog2(VALUE_BITS)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sitcrd_pkg::ctrl_cmd_t                cmd,
  output sitcrd_pkg::dp_stat_t                 stat,
  input  logic [S_DATA_W-1:0]                  s_tdata,
  input  logic                                 cfg_valid,
  input  logic [sitcrd_pkg::RADIX_W-1:0]       cfg_data,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [sitcrd_pkg::CHAR_W-1:0]        m_tdata,
  output logic                                 m_tlast
);

  localparam int RW = sitcrd_pkg::RADIX_W;
  localparam int CW = sitcrd_pkg::CNT_W;

  logic [RW-1:0]                     radix;
  logic [CW-1:0]                     cnt;
  logic [VALUE_BITS-1:0]             mag;
  logic                              neg;
  logic [RW-1:0]                     rem;
  logic [RW:0]                       rem_sh;
  logic [RW:0]                       rem_sub;
  logic                              ge;
  logic [BC_W-1:0]                   bitcnt;
  logic [DEP_W-1:0]                  depth;
  logic [DEP_W-1:0]                  dep_m1;

  logic [sitcrd_pkg::SLOT_W-1:0]     slot_in;
  logic [sitcrd_pkg::CHAR_W-1:0]     symbol_in;
  logic [VALUE_BITS-1:0]             value_in;
  logic                              slot_ok;

  logic [TAB_AW-1:0]                 tab_raddr;
  logic [sitcrd_pkg::CHAR_W-1:0]     tab_rdata;
  logic                              seen_we;
  logic [sitcrd_pkg::SEEN_AW-1:0]    seen_waddr;
  logic                              seen_rdata;
  logic [sitcrd_pkg::DIGIT_W-1:0]    stk_rdata;

  assign slot_in   = s_tdata[sitcrd_pkg::SLOT_W-1:0];
  assign symbol_in = s_tdata[sitcrd_pkg::SLOT_W +: sitcrd_pkg::CHAR_W];
  assign value_in  = s_tdata[sitcrd_pkg::IN_FIXED_BITS +: VALUE_BITS];
  assign slot_ok   = int'(slot_in) < SYMBOL_SLOTS;

  assign tab_raddr = cmd.tab_rd_digit ? TAB_AW'(stk_rdata) : TAB_AW'(cnt);

  sitcrd_ram #(.WIDTH(sitcrd_pkg::CHAR_W), .DEPTH(SYMBOL_SLOTS)) u_table (
    .clk   (clk),
    .we    (cmd.load && slot_ok),
    .waddr (TAB_AW'(slot_in)),
    .wdata (symbol_in),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  // the symbol under test stays on tab_rdata while its seen bit is checked
  assign seen_we    = cmd.clr_wr || cmd.seen_mark;
  assign seen_waddr = cmd.clr_wr ? cnt[sitcrd_pkg::SEEN_AW-1:0]
                                 : tab_rdata[sitcrd_pkg::SEEN_AW-1:0];

  sitcrd_ram #(.WIDTH(1), .DEPTH(sitcrd_pkg::SEEN_DEPTH)) u_seen (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (cmd.seen_mark),
    .raddr (tab_rdata[sitcrd_pkg::SEEN_AW-1:0]),
    .rdata (seen_rdata)
  );

  assign dep_m1 = depth - 1'b1;

  sitcrd_ram #(.WIDTH(sitcrd_pkg::DIGIT_W), .DEPTH(VALUE_BITS)) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (depth[STK_AW-1:0]),
    .wdata (rem[sitcrd_pkg::DIGIT_W-1:0]),
    .raddr (dep_m1[STK_AW-1:0]),
    .rdata (stk_rdata)
  );

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem, mag[VALUE_BITS-1]};
  assign ge      = rem_sh >= {1'b0, radix};
  assign rem_sub = rem_sh - {1'b0, radix};

  always_ff @(posedge clk) begin
    if (rst) begin
      radix    <= sitcrd_pkg::RADIX_RESET;
      cnt      <= '0;
      bitcnt   <= '0;
      depth    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        radix <= cfg_data;
      end

      if (cmd.capture) begin
        cnt <= '0;
      end else if (cmd.clr_wr) begin
        cnt <= stat.clr_last ? '0 : cnt + 1'b1;
      end else if (cmd.seen_mark) begin
        cnt <= cnt + 1'b1;
      end

      if (cmd.capture) begin
        bitcnt <= '0;
        depth  <= '0;
      end else if (cmd.div_step) begin
        bitcnt <= bitcnt + 1'b1;
      end else if (cmd.push) begin
        bitcnt <= '0;
        depth  <= depth + 1'b1;
      end else if (cmd.emit_digit) begin
        depth <= dep_m1;
      end

      if (cmd.emit_sign || cmd.emit_digit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      neg <= value_in[VALUE_BITS-1];
      mag <= value_in[VALUE_BITS-1] ? (~value_in + 1'b1) : value_in;
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
      mag <= {mag[VALUE_BITS-2:0], ge};
    end else if (cmd.push) begin
      rem <= '0;
    end

    if (cmd.emit_sign) begin
      m_tdata <= sitcrd_pkg::CH_MINUS;
      m_tlast <= 1'b0;
    end else if (cmd.emit_digit) begin
      m_tdata <= tab_rdata;
      m_tlast <= stat.depth_one;
    end
  end

  always_comb begin
    stat.len_bad   = (radix < RW'(sitcrd_pkg::MIN_RADIX)) || (int'(radix) > SYMBOL_SLOTS);
    stat.sym_bad   = (tab_rdata <= sitcrd_pkg::SYM_LOW) || (tab_rdata >= sitcrd_pkg::SYM_HIGH)
                     || (tab_rdata == sitcrd_pkg::CH_MINUS) || (tab_rdata == sitcrd_pkg::CH_PLUS);
    stat.seen_hit  = seen_rdata;
    stat.k_last    = ((CW+1)'(cnt) + 1'b1) == (CW+1)'(radix);
    stat.clr_last  = cnt == CW'(sitcrd_pkg::SEEN_DEPTH - 1);
    stat.neg       = neg;
    stat.div_last  = bitcnt == BC_W'(VALUE_BITS - 1);
    stat.quot_zero = mag == '0;
    stat.depth_one = depth == DEP_W'(1);
    stat.out_free  = !m_tvalid || m_tready;
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> depth < DEP_W'(VALUE_BITS))
    else $error("digit stack overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit |-> depth != '0)
    else $error("digit emitted from empty stack");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |=> m_tvalid)
    else $error("emitted character not presented");

endmodule

// ----- rtl/sitcrd_ctrl.sv -----
// ----------------------------------------------------------------------------
// sitcrd_ctrl
// Sequencer: base validation, digit generation by repeated division,
// and most-significant-first character output.
// ----------------------------------------------------------------------------
module sitcrd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tuser,
  output logic                  s_tready,
  input  sitcrd_pkg::dp_stat_t  stat,
  output sitcrd_pkg::ctrl_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_VRD   = 4'd2;
  localparam logic [3:0] S_VSYM  = 4'd3;
  localparam logic [3:0] S_VSEEN = 4'd4;
  localparam logic [3:0] S_SIGN  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_PUSH  = 4'd7;
  localparam logic [3:0] S_PRD   = 4'd8;
  localparam logic [3:0] S_PSTK  = 4'd9;
  localparam logic [3:0] S_PTAB  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == sitcrd_pkg::REQ_LOAD) begin
            cmd.load = 1'b1;
          end else if (!stat.len_bad) begin
            cmd.capture = 1'b1;
            state_next  = S_CLR;
          end
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_VRD;
        end
      end
      S_VRD: begin
        state_next = S_VSYM;
      end
      S_VSYM: begin
        state_next = stat.sym_bad ? S_IDLE : S_VSEEN;
      end
      S_VSEEN: begin
        if (stat.seen_hit) begin
          state_next = S_IDLE;
        end else begin
          cmd.seen_mark = 1'b1;
          if (!stat.k_last) begin
            state_next = S_VRD;
          end else begin
            state_next = stat.neg ? S_SIGN : S_DIV;
          end
        end
      end
      S_SIGN: begin
        if (stat.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = stat.quot_zero ? S_PRD : S_DIV;
      end
      S_PRD: begin
        state_next = S_PSTK;
      end
      S_PSTK: begin
        cmd.tab_rd_digit = 1'b1;
        state_next       = S_PTAB;
      end
      S_PTAB: begin
        cmd.tab_rd_digit = 1'b1;
        if (stat.out_free) begin
          cmd.emit_digit = 1'b1;
          state_next     = stat.depth_one ? S_IDLE : S_PRD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.capture, cmd.clr_wr, cmd.seen_mark, cmd.div_step,
              cmd.push, cmd.emit_sign, cmd.emit_digit}))
    else $error("conflicting datapath commands");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> stat.out_free)
    else $error("output register overwritten");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_digit && stat.depth_one) |=> s_tready)
    else $error("not idle after final character");

endmodule
